### rtl/core/hmdp_pkg.sv
package hmdp_pkg;

  localparam int unsigned UsageSlots = 8;
  localparam int unsigned SlotIdxW   = (UsageSlots > 1) ? $clog2(UsageSlots) : 1;
  localparam int unsigned FillW      = $clog2(UsageSlots + 1);

  localparam logic [7:0] LongPrefix = 8'hFE;

  // item tags (prefix bits 7:4)
  localparam logic [3:0] TagInput       = 4'h8;
  localparam logic [3:0] TagUsagePage   = 4'h0;
  localparam logic [3:0] TagLogicalMin  = 4'h1;
  localparam logic [3:0] TagReportSize  = 4'h7;
  localparam logic [3:0] TagReportId    = 4'h8;
  localparam logic [3:0] TagReportCount = 4'h9;
  localparam logic [3:0] TagUsage       = 4'h0;

  localparam logic [15:0] PageDesktop = 16'h0001;
  localparam logic [15:0] PageButton  = 16'h0009;
  localparam logic [15:0] UsageX      = 16'h0030;
  localparam logic [15:0] UsageY      = 16'h0031;
  localparam logic [15:0] ReportIdBits = 16'd8;

  typedef enum logic [1:0] {
    ITEM_MAIN   = 2'd0,
    ITEM_GLOBAL = 2'd1,
    ITEM_LOCAL  = 2'd2,
    ITEM_RSVD   = 2'd3
  } item_type_e;

  typedef struct packed {
    logic                hit;
    logic [SlotIdxW-1:0] idx;
  } axis_hit_t;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [7:0]  size;
    logic        sgn;
  } axis_rec_t;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [4:0]  size;
    logic [4:0]  count;
  } btn_rec_t;

  function automatic logic [2:0] data_len(input logic [1:0] sz);
    return (sz == 2'd3) ? 3'd4 : {1'b0, sz};
  endfunction

  function automatic logic [4:0] sat31(input logic [15:0] v);
    return (v > 16'd31) ? 5'd31 : v[4:0];
  endfunction

endpackage

### rtl/core/hmdp_if.sv
interface hmdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, desc_byte, last_byte, input ready);
  modport sink   (input valid, desc_byte, last_byte, output ready);
endinterface

interface hmdp_out_if;
  logic        valid;
  logic        ready;
  logic        layout_ok;
  logic [7:0]  rpt_id;
  logic        button_found;
  logic [15:0] button_offset;
  logic [4:0]  button_size;
  logic [4:0]  button_count;
  logic [15:0] x_offset;
  logic [7:0]  x_size;
  logic        x_signed;
  logic [15:0] y_offset;
  logic [7:0]  y_size;
  logic        y_signed;

  modport source (
    output valid, layout_ok, rpt_id, button_found, button_offset, button_size,
           button_count, x_offset, x_size, x_signed, y_offset, y_size, y_signed,
    input  ready
  );
  modport sink (
    input  valid, layout_ok, rpt_id, button_found, button_offset, button_size,
           button_count, x_offset, x_size, x_signed, y_offset, y_size, y_signed,
    output ready
  );
endinterface

### rtl/core/hmdp_axis_find.sv
module hmdp_axis_find (
  input  logic [15:0]                 usage_i [hmdp_pkg::UsageSlots],
  input  logic [hmdp_pkg::FillW-1:0]  fill_i,
  input  logic [15:0]                 count_i,
  input  logic [15:0]                 want_i,
  output hmdp_pkg::axis_hit_t         hit_o
);

  // lowest matching slot wins
  always_comb begin
    hit_o = '0;
    for (int f = hmdp_pkg::UsageSlots - 1; f >= 0; f--) begin
      if ((hmdp_pkg::FillW'(f) < fill_i) && (16'(f) < count_i) && (usage_i[f] == want_i)) begin
        hit_o.hit = 1'b1;
        hit_o.idx = hmdp_pkg::SlotIdxW'(f);
      end
    end
  end

endmodule

### rtl/core/hid_mouse_descriptor_parser_top.sv
// channel  dir  handshake      payload
// in_i     in   valid/ready    desc_byte[7:0], last_byte
// out_o    out  valid/ready    layout fields (one item per descriptor)
//
// One descriptor byte is taken per cycle while in_i.ready is high; the item decode, usage match and
// offset update for that byte finish in the same cycle.
// The layout item is registered at the edge that takes the last byte and is
// valid on out_o from the next cycle.
// in_i.ready drops only while a layout item waits on out_o.
// Reset is asynchronous, active low; parser state also clears after each last byte.
module hid_mouse_descriptor_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  hmdp_in_if.sink    in_i,
  hmdp_out_if.source out_o
);

  typedef enum logic [2:0] {
    PH_PREFIX   = 3'd0,
    PH_D0       = 3'd1,
    PH_D1       = 3'd2,
    PH_D2       = 3'd3,
    PH_D3       = 3'd4,
    PH_LONGSIZE = 3'd5,
    PH_LONGSKIP = 3'd6
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [7:0]                 prefix_q, prefix_d;
  logic [15:0]                accum_q, accum_d;
  logic [7:0]                 skip_q, skip_d;
  logic [15:0]                off_q, off_d;
  logic [15:0]                page_q, page_d;
  logic [hmdp_pkg::FillW-1:0] fill_q, fill_d;
  logic [15:0]                size_q, size_d;
  logic [15:0]                count_q, count_d;
  logic                       minneg_q, minneg_d;
  logic [7:0]                 rid_q, rid_d;
  hmdp_pkg::btn_rec_t         btn_q, btn_d;
  hmdp_pkg::axis_rec_t        x_q, x_d, y_q, y_d;
  logic [15:0]                usage_q [hmdp_pkg::UsageSlots];

  logic                       out_valid_q;
  logic                       res_ok_q;
  logic [7:0]                 res_rid_q;
  hmdp_pkg::btn_rec_t         res_btn_q;
  hmdp_pkg::axis_rec_t        res_x_q, res_y_q;

  logic                       in_acc;
  logic                       run;
  logic                       usage_we;
  logic [7:0]                 pfx;
  logic [15:0]                dat;
  logic                       neg;
  logic [1:0]                 dk;
  logic [2:0]                 dlen;
  logic                       is_const;
  hmdp_pkg::axis_hit_t        x_hit, y_hit;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;

  hmdp_axis_find u_find_x (
    .usage_i (usage_q),
    .fill_i  (fill_q),
    .count_i (count_q),
    .want_i  (hmdp_pkg::UsageX),
    .hit_o   (x_hit)
  );

  hmdp_axis_find u_find_y (
    .usage_i (usage_q),
    .fill_i  (fill_q),
    .count_i (count_q),
    .want_i  (hmdp_pkg::UsageY),
    .hit_o   (y_hit)
  );

  always_comb begin
    phase_d  = phase_q;
    prefix_d = prefix_q;
    accum_d  = accum_q;
    skip_d   = skip_q;
    off_d    = off_q;
    page_d   = page_q;
    fill_d   = fill_q;
    size_d   = size_q;
    count_d  = count_q;
    minneg_d = minneg_q;
    rid_d    = rid_q;
    btn_d    = btn_q;
    x_d      = x_q;
    y_d      = y_q;
    usage_we = 1'b0;
    run      = 1'b0;
    pfx      = prefix_q;
    dat      = accum_q;
    neg      = 1'b0;
    dk       = 2'(3'(phase_q) - 3'd1);

    // byte framing
    case (phase_q)
      PH_PREFIX: begin
        if (in_i.desc_byte == hmdp_pkg::LongPrefix) begin
          phase_d = PH_LONGSIZE;
        end else begin
          prefix_d = in_i.desc_byte;
          accum_d  = '0;
          pfx      = in_i.desc_byte;
          dat      = '0;
          if (in_i.desc_byte[1:0] == 2'd0) begin
            run = 1'b1;
          end else begin
            phase_d = PH_D0;
          end
        end
      end
      PH_LONGSIZE: begin
        skip_d  = in_i.desc_byte;
        phase_d = (in_i.desc_byte != 8'd0) ? PH_LONGSKIP : PH_PREFIX;
      end
      PH_LONGSKIP: begin
        skip_d = skip_q - 8'd1;
        if (skip_q == 8'd1) begin
          phase_d = PH_PREFIX;
        end
      end
      PH_D0, PH_D1, PH_D2, PH_D3: begin
        case (dk)
          2'd0:    dat = {accum_q[15:8], in_i.desc_byte};
          2'd1:    dat = {in_i.desc_byte, accum_q[7:0]};
          default: dat = accum_q;
        endcase
        accum_d = dat;
        if (({1'b0, dk} + 3'd1) >= hmdp_pkg::data_len(prefix_q[1:0])) begin
          run     = 1'b1;
          neg     = in_i.desc_byte[7];
          phase_d = PH_PREFIX;
        end else begin
          phase_d = phase_e'(3'(phase_q) + 3'd1);
        end
      end
      default: phase_d = PH_PREFIX;
    endcase

    dlen     = hmdp_pkg::data_len(pfx[1:0]);
    is_const = (dlen != 3'd0) & dat[0];

    // item execution
    if (run) begin
      case (hmdp_pkg::item_type_e'(pfx[3:2]))
        hmdp_pkg::ITEM_GLOBAL: begin
          case (pfx[7:4])
            hmdp_pkg::TagUsagePage:   page_d   = dat;
            hmdp_pkg::TagLogicalMin:  minneg_d = neg;
            hmdp_pkg::TagReportSize:  size_d   = dat;
            hmdp_pkg::TagReportId: begin
              rid_d = dat[7:0];
              off_d = off_q + hmdp_pkg::ReportIdBits;
            end
            hmdp_pkg::TagReportCount: count_d  = dat;
            default: ;
          endcase
        end
        hmdp_pkg::ITEM_LOCAL: begin
          if ((pfx[7:4] == hmdp_pkg::TagUsage) &&
              (fill_q < hmdp_pkg::FillW'(hmdp_pkg::UsageSlots))) begin
            usage_we = 1'b1;
            fill_d   = fill_q + hmdp_pkg::FillW'(1);
          end
        end
        hmdp_pkg::ITEM_MAIN: begin
          if (pfx[7:4] == hmdp_pkg::TagInput) begin
            if (!is_const && (count_q != 16'd0)) begin
              if (page_q == hmdp_pkg::PageButton) begin
                if (!btn_q.found) begin
                  btn_d.found  = 1'b1;
                  btn_d.offset = off_q;
                  btn_d.size   = hmdp_pkg::sat31(size_q);
                  btn_d.count  = hmdp_pkg::sat31(count_q);
                end
              end else if (page_q == hmdp_pkg::PageDesktop) begin
                if (!x_q.found && x_hit.hit) begin
                  x_d.found  = 1'b1;
                  x_d.offset = off_q + 16'(16'(x_hit.idx) * size_q);
                  x_d.size   = size_q[7:0];
                  x_d.sgn    = minneg_q;
                end
                if (!y_q.found && y_hit.hit) begin
                  y_d.found  = 1'b1;
                  y_d.offset = off_q + 16'(16'(y_hit.idx) * size_q);
                  y_d.size   = size_q[7:0];
                  y_d.sgn    = minneg_q;
                end
              end
            end
            off_d = off_q + 16'(size_q * count_q);
          end
          fill_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      prefix_q    <= '0;
      accum_q     <= '0;
      skip_q      <= '0;
      off_q       <= '0;
      page_q      <= '0;
      fill_q      <= '0;
      size_q      <= '0;
      count_q     <= '0;
      minneg_q    <= 1'b0;
      rid_q       <= '0;
      btn_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && in_i.last_byte) begin
        phase_q  <= PH_PREFIX;
        prefix_q <= '0;
        accum_q  <= '0;
        skip_q   <= '0;
        off_q    <= '0;
        page_q   <= '0;
        fill_q   <= '0;
        size_q   <= '0;
        count_q  <= '0;
        minneg_q <= 1'b0;
        rid_q    <= '0;
        btn_q    <= '0;
        x_q      <= '0;
        y_q      <= '0;
      end else if (in_acc) begin
        phase_q  <= phase_d;
        prefix_q <= prefix_d;
        accum_q  <= accum_d;
        skip_q   <= skip_d;
        off_q    <= off_d;
        page_q   <= page_d;
        fill_q   <= fill_d;
        size_q   <= size_d;
        count_q  <= count_d;
        minneg_q <= minneg_d;
        rid_q    <= rid_d;
        btn_q    <= btn_d;
        x_q      <= x_d;
        y_q      <= y_d;
      end
      if (in_acc && in_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && usage_we) begin
      usage_q[fill_q[hmdp_pkg::SlotIdxW-1:0]] <= dat;
    end
    if (in_acc && in_i.last_byte) begin
      res_ok_q  <= x_d.found & y_d.found;
      res_rid_q <= rid_d;
      res_btn_q <= btn_d;
      res_x_q   <= x_d;
      res_y_q   <= y_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.layout_ok     = res_ok_q;
  assign out_o.rpt_id        = res_rid_q;
  assign out_o.button_found  = res_btn_q.found;
  assign out_o.button_offset = res_btn_q.offset;
  assign out_o.button_size   = res_btn_q.size;
  assign out_o.button_count  = res_btn_q.count;
  assign out_o.x_offset      = res_x_q.offset;
  assign out_o.x_size        = res_x_q.size;
  assign out_o.x_signed      = res_x_q.sgn;
  assign out_o.y_offset      = res_y_q.offset;
  assign out_o.y_size        = res_y_q.size;
  assign out_o.y_signed      = res_y_q.sgn;

endmodule

### rtl/core/hmdp_checker.sv
module hmdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        layout_ok_i,
  input logic        button_found_i,
  input logic [15:0] button_offset_i,
  input logic [4:0]  button_size_i,
  input logic [4:0]  button_count_i,
  input logic [15:0] x_offset_i,
  input logic [15:0] y_offset_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(layout_ok_i) &&
      $stable(button_offset_i) && $stable(x_offset_i) && $stable(y_offset_i)))
    else $error("layout item changed while stalled");

  a_last_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> out_valid_i)
    else $error("no layout item after last byte");

  a_item_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !($past(out_valid_i) && !$past(out_ready_i))) |->
      $past(in_valid_i && in_ready_i && in_last_i))
    else $error("layout item without a last byte");

  a_no_button_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !button_found_i) |->
      (button_offset_i == 16'd0 && button_size_i == 5'd0 && button_count_i == 5'd0))
    else $error("button fields set without a button block");

endmodule

bind hid_mouse_descriptor_parser_top hmdp_checker u_hmdp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_last_i       (in_i.last_byte),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .layout_ok_i     (out_o.layout_ok),
  .button_found_i  (out_o.button_found),
  .button_offset_i (out_o.button_offset),
  .button_size_i   (out_o.button_size),
  .button_count_i  (out_o.button_count),
  .x_offset_i      (out_o.x_offset),
  .y_offset_i      (out_o.y_offset)
);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned StimBytes    = 950;
  localparam int unsigned SettleCycles = 8;

  localparam logic [2:0] PhPrefix   = 3'd0;
  localparam logic [2:0] PhLongLen  = 3'd5;
  localparam logic [2:0] PhLongSkip = 3'd6;

  localparam logic [3:0] TagUsageMin   = 4'h1;
  localparam logic [3:0] TagUsageMax   = 4'h2;
  localparam logic [3:0] TagLogicalMax = 4'h2;
  localparam logic [3:0] TagOutput     = 4'h9;
  localparam logic [3:0] TagCollection = 4'hA;
  localparam logic [3:0] TagFeature    = 4'hB;
  localparam logic [3:0] TagEndColl    = 4'hC;

  localparam logic [15:0] InConst    = 16'h0001;
  localparam logic [15:0] InDataVar  = 16'h0002;
  localparam logic [15:0] InPadding  = 16'h0003;
  localparam logic [15:0] UsageWheel = 16'h0038;
  localparam logic [15:0] SatMax     = 16'd31;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       hold;
  } stim_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  rid;
    logic        bfound;
    logic [15:0] boff;
    logic [4:0]  bsize;
    logic [4:0]  bcount;
    logic [15:0] xoff;
    logic [7:0]  xsize;
    logic        xsgn;
    logic [15:0] yoff;
    logic [7:0]  ysize;
    logic        ysgn;
  } layout_t;

  logic clk_i;
  logic rst_ni;

  hmdp_in_if  in_if ();
  hmdp_out_if out_if ();

  hid_mouse_descriptor_parser_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  stim_t       desc_q[$];
  layout_t     layout_q[$];
  int unsigned err_cnt   = 0;
  int unsigned taken_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_wait   = 0;
  int unsigned rx_wait   = 0;
  int unsigned tx_calm   = 0;
  int unsigned rx_calm   = 0;
  int unsigned rx_draw;
  layout_t     want;

  // parser shadow state
  logic [2:0]                 ph;
  logic [7:0]                 pfx;
  logic [31:0]                acc;
  logic [8:0]                 skip_left;
  logic [15:0]                bitpos;
  logic [15:0]                page;
  logic [15:0]                usages[hmdp_pkg::UsageSlots];
  logic [hmdp_pkg::FillW-1:0] n_usages;
  logic [15:0]                rsize;
  logic [15:0]                rcount;
  logic                       lmin_neg;
  logic [7:0]                 rid;
  hmdp_pkg::btn_rec_t         btn;
  hmdp_pkg::axis_rec_t        xax;
  hmdp_pkg::axis_rec_t        yax;

  function automatic bit chance(input int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if (chance(25)) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic int unsigned payload_len(input logic [1:0] code);
    case (code)
      2'd0: return 0;
      2'd1: return 1;
      2'd2: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic void clear_parser();
    ph        = PhPrefix;
    pfx       = '0;
    acc       = '0;
    skip_left = '0;
    bitpos    = '0;
    page      = '0;
    n_usages  = '0;
    rsize     = '0;
    rcount    = '0;
    lmin_neg  = 1'b0;
    rid       = '0;
    btn       = '0;
    xax       = '0;
    yax       = '0;
  endfunction

  function automatic void locate_axis(inout hmdp_pkg::axis_rec_t r,
                                      input logic [15:0] wanted);
    if (r.found || page != hmdp_pkg::PageDesktop) return;
    for (int f = 0; f < hmdp_pkg::UsageSlots; f++) begin
      if (f < n_usages && f < rcount && usages[f] == wanted) begin
        r.found  = 1'b1;
        r.offset = bitpos + 16'(f) * rsize;
        r.size   = rsize[7:0];
        r.sgn    = lmin_neg;
        return;
      end
    end
  endfunction

  function automatic void apply_item();
    hmdp_pkg::item_type_e kind;
    logic [3:0]           tag;
    int unsigned          nbytes;
    logic                 is_const;
    kind   = hmdp_pkg::item_type_e'(pfx[3:2]);
    tag    = pfx[7:4];
    nbytes = payload_len(pfx[1:0]);
    case (kind)
      hmdp_pkg::ITEM_GLOBAL: begin
        if (tag == hmdp_pkg::TagUsagePage) begin
          page = acc[15:0];
        end else if (tag == hmdp_pkg::TagLogicalMin) begin
          case (nbytes)
            1: lmin_neg = acc[7];
            2: lmin_neg = acc[15];
            4: lmin_neg = acc[31];
            default: lmin_neg = 1'b0;
          endcase
        end else if (tag == hmdp_pkg::TagReportSize) begin
          rsize = acc[15:0];
        end else if (tag == hmdp_pkg::TagReportId) begin
          rid    = acc[7:0];
          bitpos = bitpos + hmdp_pkg::ReportIdBits;
        end else if (tag == hmdp_pkg::TagReportCount) begin
          rcount = acc[15:0];
        end
      end
      hmdp_pkg::ITEM_LOCAL: begin
        if (tag == hmdp_pkg::TagUsage && n_usages < hmdp_pkg::UsageSlots) begin
          usages[n_usages[hmdp_pkg::SlotIdxW-1:0]] = acc[15:0];
          n_usages++;
        end
      end
      hmdp_pkg::ITEM_MAIN: begin
        if (tag == hmdp_pkg::TagInput) begin
          is_const = (nbytes != 0) && acc[0];
          if (!is_const && rcount != 0) begin
            if (page == hmdp_pkg::PageButton) begin
              if (!btn.found) begin
                btn.found  = 1'b1;
                btn.offset = bitpos;
                btn.size   = (rsize > SatMax) ? SatMax[4:0] : rsize[4:0];
                btn.count  = (rcount > SatMax) ? SatMax[4:0] : rcount[4:0];
              end
            end else begin
              locate_axis(xax, hmdp_pkg::UsageX);
              locate_axis(yax, hmdp_pkg::UsageY);
            end
          end
          bitpos = bitpos + 16'(rsize * rcount);
        end
        n_usages = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    int unsigned k;
    layout_t     lay;
    case (ph)
      PhPrefix: begin
        if (b == hmdp_pkg::LongPrefix) begin
          ph = PhLongLen;
        end else begin
          pfx = b;
          acc = '0;
          if (payload_len(b[1:0]) == 0) apply_item();
          else ph = 3'd1;
        end
      end
      PhLongLen: begin
        skip_left = {1'b0, b};
        ph = (b != 0) ? PhLongSkip : PhPrefix;
      end
      PhLongSkip: begin
        skip_left = skip_left - 9'd1;
        if (skip_left == 0) ph = PhPrefix;
      end
      default: begin
        k = ph - 1;
        acc = acc | (32'(b) << (8 * k));
        if (k + 1 >= payload_len(pfx[1:0])) begin
          apply_item();
          ph = PhPrefix;
        end else begin
          ph = ph + 3'd1;
        end
      end
    endcase
    if (fin) begin
      lay.ok     = xax.found && yax.found;
      lay.rid    = rid;
      lay.bfound = btn.found;
      lay.boff   = btn.offset;
      lay.bsize  = btn.size;
      lay.bcount = btn.count;
      lay.xoff   = xax.offset;
      lay.xsize  = xax.size;
      lay.xsgn   = xax.sgn;
      lay.yoff   = yax.offset;
      lay.ysize  = yax.size;
      lay.ysgn   = yax.sgn;
      layout_q.push_back(lay);
      clear_parser();
    end
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val) flag_error($sformatf("%s got %0h exp %0h", name, got, exp_val));
  endtask

  task automatic put_byte(input logic [7:0] b);
    stim_t s;
    s.b    = b;
    s.fin  = 1'b0;
    s.hold = 1'b0;
    desc_q.push_back(s);
  endtask

  task automatic put_item(input logic [3:0] tag, input hmdp_pkg::item_type_e kind,
                          input logic [31:0] val, input int unsigned n);
    logic [1:0] code;
    code = (n == 4) ? 2'd3 : 2'(n);
    put_byte({tag, kind, code});
    for (int i = 0; i < n; i++) put_byte(val[8*i +: 8]);
  endtask

  task automatic put_short(input logic [3:0] tag, input hmdp_pkg::item_type_e kind,
                           input logic [15:0] val);
    int unsigned n;
    if (val[15:8] != 0) begin
      n = chance(3) ? 4 : 2;
    end else if (val == 0 && chance(3)) begin
      n = 0;
    end else begin
      case ($urandom_range(0, 3))
        0, 1: n = 1;
        2: n = 2;
        default: n = 4;
      endcase
    end
    put_item(tag, kind, {16'($urandom_range(0, 65535)), val}, n);
  endtask

  task automatic put_noise_item();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    put_item(b[7:4], hmdp_pkg::item_type_e'(b[3:2]), $urandom, payload_len(b[1:0]));
  endtask

  task automatic end_desc();
    stim_t s;
    s = desc_q.pop_back();
    s.fin = 1'b1;
    desc_q.push_back(s);
  endtask

  function automatic logic [15:0] pick_size();
    return chance(10) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(1, 16));
  endfunction

  function automatic logic [15:0] pick_count();
    return chance(10) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 4));
  endfunction

  function automatic logic [15:0] pick_flags();
    if (chance(6)) return InConst;
    if (chance(5)) return 16'h0000;
    return InDataVar;
  endfunction

  // mouse-like descriptor with random content, which may hold noise items and a cut-off last item
  task automatic gen_mouse();
    int unsigned n_ax;
    int unsigned n_skip;
    int unsigned n_len;
    logic [15:0] u;
    logic [7:0]  p;
    if (chance(2)) begin
      put_short(hmdp_pkg::TagReportId, hmdp_pkg::ITEM_GLOBAL, 16'($urandom_range(0, 255)));
    end
    if (chance(4)) put_noise_item();
    if (chance(2)) begin
      put_short(hmdp_pkg::TagUsagePage, hmdp_pkg::ITEM_GLOBAL, hmdp_pkg::PageButton);
      put_short(TagUsageMin, hmdp_pkg::ITEM_LOCAL, 16'd1);
      put_short(TagUsageMax, hmdp_pkg::ITEM_LOCAL, 16'($urandom_range(1, 40)));
      put_short(hmdp_pkg::TagReportSize, hmdp_pkg::ITEM_GLOBAL, pick_size());
      put_short(hmdp_pkg::TagReportCount, hmdp_pkg::ITEM_GLOBAL, pick_count());
      put_short(hmdp_pkg::TagInput, hmdp_pkg::ITEM_MAIN, pick_flags());
    end
    if (chance(3)) begin
      put_short(hmdp_pkg::TagReportSize, hmdp_pkg::ITEM_GLOBAL, pick_size());
      put_short(hmdp_pkg::TagReportCount, hmdp_pkg::ITEM_GLOBAL, 16'd1);
      put_short(hmdp_pkg::TagInput, hmdp_pkg::ITEM_MAIN, InPadding);
    end
    if (chance(3)) put_short(TagCollection, hmdp_pkg::ITEM_MAIN, 16'($urandom_range(0, 2)));
    put_short(hmdp_pkg::TagUsagePage, hmdp_pkg::ITEM_GLOBAL,
              chance(8) ? 16'($urandom_range(0, 65535)) : hmdp_pkg::PageDesktop);
    n_ax = chance(10) ? $urandom_range(8, 11) : $urandom_range(1, 3);
    repeat (n_ax) begin
      case ($urandom_range(0, 5))
        0, 1: u = hmdp_pkg::UsageX;
        2, 3: u = hmdp_pkg::UsageY;
        4: u = UsageWheel;
        default: u = 16'($urandom_range(0, 65535));
      endcase
      put_short(hmdp_pkg::TagUsage, hmdp_pkg::ITEM_LOCAL, u);
    end
    case ($urandom_range(0, 3))
      0: n_len = 0;
      1: n_len = 1;
      2: n_len = 2;
      default: n_len = 4;
    endcase
    put_item(hmdp_pkg::TagLogicalMin, hmdp_pkg::ITEM_GLOBAL, $urandom, n_len);
    if (chance(2)) begin
      put_short(TagLogicalMax, hmdp_pkg::ITEM_GLOBAL, 16'($urandom_range(0, 65535)));
    end
    put_short(hmdp_pkg::TagReportSize, hmdp_pkg::ITEM_GLOBAL, pick_size());
    put_short(hmdp_pkg::TagReportCount, hmdp_pkg::ITEM_GLOBAL,
              chance(2) ? 16'($urandom_range(1, 3)) : pick_count());
    if (chance(8)) put_short(TagOutput, hmdp_pkg::ITEM_MAIN, InDataVar);
    put_short(hmdp_pkg::TagInput, hmdp_pkg::ITEM_MAIN, pick_flags());
    if (chance(3)) begin
      case ($urandom_range(0, 2))
        0: put_short(TagEndColl, hmdp_pkg::ITEM_MAIN, 16'h0000);
        1: put_short(TagOutput, hmdp_pkg::ITEM_MAIN, InDataVar);
        default: put_short(TagFeature, hmdp_pkg::ITEM_MAIN, InDataVar);
      endcase
    end
    if (chance(6)) put_noise_item();
    if (chance(4)) begin
      n_skip = chance(10) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      put_byte(hmdp_pkg::LongPrefix);
      put_byte(8'(n_skip));
      repeat (n_skip) put_byte(8'($urandom_range(0, 255)));
    end
    // item cut off by the end of the descriptor
    if (chance(5)) begin
      p = {6'($urandom_range(0, 63)), 2'($urandom_range(1, 3))};
      put_byte(p);
      repeat ($urandom_range(0, payload_len(p[1:0]) - 1)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.desc_byte <= '0;
      in_if.last_byte <= 1'b0;
      tx_wait         <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.desc_byte, in_if.last_byte);
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_wait != 0) begin
          tx_wait     <= tx_wait - 1;
          in_if.valid <= 1'b0;
        end else if (desc_q.size() != 0 && !(desc_q[0].hold && layout_q.size() != 0)) begin
          in_if.valid     <= 1'b1;
          in_if.desc_byte <= desc_q[0].b;
          in_if.last_byte <= desc_q[0].fin;
          void'(desc_q.pop_front());
          tx_wait <= draw_wait(tx_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // layout monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (layout_q.size() == 0) begin
          flag_error("layout item with nothing expected");
        end else begin
          want = layout_q.pop_front();
          check_field("layout_ok", out_if.layout_ok, want.ok);
          check_field("rpt_id", out_if.rpt_id, want.rid);
          check_field("button_found", out_if.button_found, want.bfound);
          check_field("button_offset", out_if.button_offset, want.boff);
          check_field("button_size", out_if.button_size, want.bsize);
          check_field("button_count", out_if.button_count, want.bcount);
          check_field("x_offset", out_if.x_offset, want.xoff);
          check_field("x_size", out_if.x_size, want.xsize);
          check_field("x_signed", out_if.x_signed, want.xsgn);
          check_field("y_offset", out_if.y_offset, want.yoff);
          check_field("y_size", out_if.y_size, want.ysize);
          check_field("y_signed", out_if.y_signed, want.ysgn);
        end
        rx_draw = draw_wait(rx_calm);
        rx_wait      <= rx_draw;
        out_if.ready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait      <= rx_wait - 1;
        out_if.ready <= (rx_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stim
    int unsigned first;
    int unsigned total;
    int unsigned n_desc;
    stim_t       s;
    rst_ni = 1'b0;
    n_desc = 0;
    clear_parser();

    // plain X/Y mouse, negative logical minimum
    put_item(hmdp_pkg::TagUsagePage, hmdp_pkg::ITEM_GLOBAL, 32'(hmdp_pkg::PageDesktop), 1);
    put_item(hmdp_pkg::TagUsage, hmdp_pkg::ITEM_LOCAL, 32'(hmdp_pkg::UsageX), 1);
    put_item(hmdp_pkg::TagUsage, hmdp_pkg::ITEM_LOCAL, 32'(hmdp_pkg::UsageY), 1);
    put_item(hmdp_pkg::TagLogicalMin, hmdp_pkg::ITEM_GLOBAL, 32'h81, 1);
    put_item(hmdp_pkg::TagReportSize, hmdp_pkg::ITEM_GLOBAL, 32'd8, 1);
    put_item(hmdp_pkg::TagReportCount, hmdp_pkg::ITEM_GLOBAL, 32'd2, 1);
    put_item(hmdp_pkg::TagInput, hmdp_pkg::ITEM_MAIN, 32'(InDataVar), 1);
    end_desc();

    // report id, long item, reserved item, non-input main, cut-off final item
    put_item(hmdp_pkg::TagReportId, hmdp_pkg::ITEM_GLOBAL, 32'hFF, 1);
    put_byte(hmdp_pkg::LongPrefix);
    put_byte(8'd1);
    put_byte(8'h00);
    put_item(hmdp_pkg::TagUsage, hmdp_pkg::ITEM_RSVD, 32'h0, 0);
    put_item(hmdp_pkg::TagUsagePage, hmdp_pkg::ITEM_GLOBAL, 32'(hmdp_pkg::PageButton), 1);
    put_item(TagEndColl, hmdp_pkg::ITEM_MAIN, 32'h0, 0);
    put_byte({hmdp_pkg::TagUsage, hmdp_pkg::ITEM_LOCAL, 2'd1});
    end_desc();

    total = desc_q.size() + StimBytes;
    while (desc_q.size() < total) begin
      first = desc_q.size();
      if (chance(4)) begin
        repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        gen_mouse();
      end
      end_desc();
      if (n_desc == 0 || chance(10)) begin
        s = desc_q[first];
        s.hold = 1'b1;
        desc_q[first] = s;
      end
      n_desc++;
    end
    total = desc_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (taken_cnt < total) @(posedge clk_i);
    while (layout_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/hmdp_pkg.sv
rtl/core/hmdp_if.sv
rtl/core/hmdp_axis_find.sv
rtl/core/hid_mouse_descriptor_parser_top.sv
rtl/core/hmdp_checker.sv
test/tb.sv
